// File: design/trte_pkg.sv
// Types and constants shared by the tree route table engine.
package trte_pkg;

  localparam logic [7:0] NoNode = 8'hff;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DST,
    ST_WALK,
    ST_FROM,
    ST_RM,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] node;
    logic [7:0] parent;
    logic [7:0] from_node;
  } req_t;

  typedef struct packed {
    logic [7:0] hop;
    logic       accepted;
    logic       walk_overrun;
  } rsp_t;

  // Table access issued by the controller; write indexes are always in range,
  // out-of-range reads are masked by the controller.
  typedef struct packed {
    logic       rd_en;
    logic [7:0] rd_idx;
    logic       wr_en;
    logic [7:0] wr_idx;
    logic [7:0] wr_data;
    logic       clr;
  } mem_cmd_t;

endpackage

// File: design/trte_req_if.sv
// Request channel: valid/ready handshake carrying one table operation.
interface trte_req_if;
  logic              valid;
  logic              ready;
  trte_pkg::req_t    data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: design/trte_rsp_if.sv
// Response channel: valid/ready handshake carrying one result word.
interface trte_rsp_if;
  logic              valid;
  logic              ready;
  trte_pkg::rsp_t    data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: design/trte_mem.sv
// Parent table: synchronous RAM with per-entry valid bits and a registered read.
module trte_mem #(
  parameter int NODES = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  trte_pkg::mem_cmd_t   cmd_i,
  output logic [7:0]           rd_data_o
);

  localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;

  logic [7:0]       mem_q [NODES];
  logic [NODES-1:0] vld_q;
  logic [7:0]       rd_data_q;
  logic             rd_vld_q;
  logic [AW-1:0]    wr_addr;
  logic [AW-1:0]    rd_addr;

  assign wr_addr = cmd_i.wr_idx[AW-1:0];
  assign rd_addr = cmd_i.rd_idx[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_addr] <= cmd_i.wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // entries not written since reset or the last clear read as no parent
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.clr) begin
        vld_q <= '0;
      end else if (cmd_i.wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (cmd_i.rd_en) begin
        rd_vld_q <= vld_q[rd_addr];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : trte_pkg::NoNode;

endmodule

// File: design/trte_ctrl.sv
// Operation sequencer: updates, remove check and the parent-chain walk.
module trte_ctrl #(
  parameter int NODES = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  trte_pkg::req_t       req_i,
  output logic                 res_valid_o,
  input  logic                 res_take_i,
  output trte_pkg::rsp_t       res_o,
  output trte_pkg::mem_cmd_t   mem_o,
  input  logic [7:0]           rd_data_i
);

  localparam int SW = $clog2(NODES + 1);
  localparam logic [8:0]    NodeLim  = 9'(NODES);
  localparam logic [SW-1:0] StepLim  = SW'(NODES);

  trte_pkg::state_e state_q, state_d;
  logic [7:0]     node_q, node_d;
  logic [7:0]     par_q, par_d;
  logic [7:0]     from_q, from_d;
  logic [7:0]     prev_q, prev_d;
  logic [SW-1:0]  steps_q, steps_d;
  logic           ovr_q, ovr_d;
  logic           rd_oor_q, rd_oor_d;
  trte_pkg::rsp_t res_q, res_d;

  logic       rd_go;
  logic [7:0] rd_idx;
  logic [7:0] rdval;
  logic       in_range;
  logic       dst_oor;

  // out-of-range reads see no parent
  assign rdval    = rd_oor_q ? trte_pkg::NoNode : rd_data_i;
  assign dst_oor  = {1'b0, req_i.node} >= NodeLim;
  assign in_range = !dst_oor && ({1'b0, req_i.parent} < NodeLim);

  always_comb begin
    state_d = state_q;
    node_d  = node_q;
    par_d   = par_q;
    from_d  = from_q;
    prev_d  = prev_q;
    steps_d = steps_q;
    ovr_d   = ovr_q;
    res_d   = res_q;
    rd_go   = 1'b0;
    rd_idx  = from_q;
    mem_o   = '0;
    req_ready_o = (state_q == trte_pkg::ST_IDLE);
    res_valid_o = (state_q == trte_pkg::ST_DONE);

    case (state_q)
      trte_pkg::ST_IDLE: begin
        if (req_valid_i) begin
          node_d  = req_i.node;
          par_d   = req_i.parent;
          from_d  = req_i.from_node;
          ovr_d   = 1'b0;
          res_d   = '{hop: trte_pkg::NoNode, accepted: 1'b0, walk_overrun: 1'b0};
          state_d = trte_pkg::ST_DONE;
          case (req_i.operation)
            trte_pkg::OP_LOOKUP: begin
              if (!dst_oor && req_i.from_node != req_i.node) begin
                rd_go   = 1'b1;
                rd_idx  = req_i.node;
                state_d = trte_pkg::ST_DST;
              end
            end
            trte_pkg::OP_ADD: begin
              if (in_range) begin
                mem_o.wr_en   = 1'b1;
                mem_o.wr_idx  = req_i.node;
                mem_o.wr_data = req_i.parent;
                res_d.accepted = 1'b1;
              end
            end
            trte_pkg::OP_REMOVE: begin
              if (in_range) begin
                rd_go   = 1'b1;
                rd_idx  = req_i.node;
                state_d = trte_pkg::ST_RM;
              end
            end
            trte_pkg::OP_CLEAR: begin
              mem_o.clr      = 1'b1;
              res_d.accepted = 1'b1;
            end
            default: ;
          endcase
        end
      end

      trte_pkg::ST_DST: begin
        res_d.accepted = 1'b1;
        if (rdval == from_q) begin
          // destination is a direct child
          res_d.hop = node_q;
          state_d   = trte_pkg::ST_DONE;
        end else if (from_q == 8'd0 || rdval != trte_pkg::NoNode) begin
          prev_d  = rdval;
          rd_go   = 1'b1;
          rd_idx  = rdval;
          steps_d = SW'(1);
          state_d = trte_pkg::ST_WALK;
        end else begin
          rd_go   = 1'b1;
          rd_idx  = from_q;
          state_d = trte_pkg::ST_FROM;
        end
      end

      trte_pkg::ST_WALK: begin
        if (rdval == from_q) begin
          res_d.hop = prev_q;
          state_d   = trte_pkg::ST_DONE;
        end else if (rdval == trte_pkg::NoNode) begin
          rd_go   = 1'b1;
          rd_idx  = from_q;
          state_d = trte_pkg::ST_FROM;
        end else if (steps_q >= StepLim) begin
          ovr_d   = 1'b1;
          rd_go   = 1'b1;
          rd_idx  = from_q;
          state_d = trte_pkg::ST_FROM;
        end else begin
          prev_d  = rdval;
          rd_go   = 1'b1;
          rd_idx  = rdval;
          steps_d = SW'(steps_q + 1'b1);
        end
      end

      trte_pkg::ST_FROM: begin
        // default route: parent of the looking node
        res_d.hop          = rdval;
        res_d.walk_overrun = ovr_q;
        state_d            = trte_pkg::ST_DONE;
      end

      trte_pkg::ST_RM: begin
        if (rdval == par_q) begin
          mem_o.wr_en    = 1'b1;
          mem_o.wr_idx   = node_q;
          mem_o.wr_data  = trte_pkg::NoNode;
          res_d.accepted = 1'b1;
        end
        state_d = trte_pkg::ST_DONE;
      end

      trte_pkg::ST_DONE: begin
        if (res_take_i) begin
          state_d = trte_pkg::ST_IDLE;
        end
      end

      default: state_d = trte_pkg::ST_IDLE;
    endcase

    mem_o.rd_en  = rd_go;
    mem_o.rd_idx = rd_idx;
    rd_oor_d     = rd_go ? ({1'b0, rd_idx} >= NodeLim) : rd_oor_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= trte_pkg::ST_IDLE;
      rd_oor_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_oor_q <= rd_oor_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q  <= node_d;
    par_q   <= par_d;
    from_q  <= from_d;
    prev_q  <= prev_d;
    steps_q <= steps_d;
    ovr_q   <= ovr_d;
    res_q   <= res_d;
  end

  assign res_o = res_q;

endmodule

// File: design/tree_route_table_engine.sv
// One word at a time through the single read port. Add, clear and rejected words go from
// the controller straight to the output register; remove first reads the node's entry, and a
// lookup reads the destination entry, walks its parent chain toward the looking node and
// else reads the looking node's parent; a walk that hits the step limit set by NODES is
// flagged as overrun. The next word is accepted the cycle after the result moves out.
// Reset: asynchronous, clears the controller, the output valid and all table valid bits.
module tree_route_table_engine #(
  parameter int NODES = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  trte_req_if.sink       req_i,
  trte_rsp_if.source     rsp_o
);

  trte_pkg::mem_cmd_t mem_cmd;
  logic [7:0]         rd_data;
  logic               res_valid;
  logic               res_take;
  trte_pkg::rsp_t     res;
  logic               out_valid_q;
  trte_pkg::rsp_t     out_data_q;

  trte_ctrl #(
    .NODES(NODES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_i.valid),
    .req_ready_o(req_i.ready),
    .req_i      (req_i.data),
    .res_valid_o(res_valid),
    .res_take_i (res_take),
    .res_o      (res),
    .mem_o      (mem_cmd),
    .rd_data_i  (rd_data)
  );

  trte_mem #(
    .NODES(NODES)
  ) u_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (mem_cmd),
    .rd_data_o(rd_data)
  );

  assign res_take = res_valid && (!out_valid_q || rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_data_q <= res;
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_data_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("ready stayed high after an accepted word");

  a_overrun_is_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.data.walk_overrun) |-> rsp_o.data.accepted)
    else $error("walk overrun reported on a rejected word");

  a_reject_no_hop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.data.accepted) |->
      (rsp_o.data.hop == trte_pkg::NoNode && !rsp_o.data.walk_overrun))
    else $error("rejected word carries a next hop");

  a_take_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !rsp_o.ready) |=> $stable(out_data_q))
    else $error("output register overwritten while stalled");

endmodule
